// ----- design/mie_pkg.sv -----
// shared types, constants and functions of the multiboot image encryptor
// no dependencies
`default_nettype none

package mie_pkg;

  localparam int OFFSET_W     = 19;
  localparam int SIZE_W       = 19;
  localparam int CFG_INDEX_W  = 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0]   MAX_IMAGE_BYTES    = 19'd262144;
  localparam logic [OFFSET_W-1:0] PLAIN_HEADER_BYTES = 19'd192;
  localparam logic [SIZE_W-1:0]   MIN_IMAGE_BYTES    = 19'h200;
  localparam logic [SIZE_W-1:0]   RAW_BYTES_RESET    = 19'd512;

  localparam logic [15:0] CRC_POLY  = 16'hA1C1;
  localparam logic [15:0] CRC_SEED  = 16'h15A0;
  localparam logic [31:0] LOAD_BASE = 32'h0200_0000;
  localparam logic [31:0] MUL_CONST = 32'h6177_614B;
  localparam logic [31:0] XOR_BY    = 32'h2079_6220;
  localparam logic [31:0] KEY_SEED  = 32'h6F64_6573;

  localparam logic [CFG_INDEX_W-1:0] REG_RAW_IMAGE_BYTES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHALLENGE_WORD  = 1'd1;

  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_PLAIN   = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_TRAILER = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  typedef struct packed {
    logic        func;
    logic [31:0] data_word;
  } in_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  out_kind;
    logic        last;
    logic        done_res;
  } out_t;

  // one result waiting for the back end
  typedef struct packed {
    logic [31:0]         word;
    logic [31:0]         key;
    logic [OFFSET_W-1:0] offset;
    logic [2:0]          kind;
    logic                last;
    logic                done_res;
  } entry_t;

  function automatic logic [SIZE_W-1:0] padded_size(logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] r;
    logic [SIZE_W-1:0] s;
    r = (raw > MAX_IMAGE_BYTES) ? MAX_IMAGE_BYTES : raw;
    s = r + 19'd7;
    s[2:0] = 3'd0;
    return (r < MIN_IMAGE_BYTES) ? MIN_IMAGE_BYTES : s;
  endfunction

  function automatic logic [31:0] size_key(logic [SIZE_W-1:0] size);
    logic [31:0] k;
    logic [31:0] sum;
    k = ({13'd0, size} - {13'd0, MIN_IMAGE_BYTES}) >> 3;
    k = (k & 32'h7F) | ((k & 32'h3F80) << 1) | ((k & 32'h4000) << 2) | 32'h0070_0000;
    sum = k + (k >> 8) + (k >> 16);
    k = k | (sum << 24) | 32'h8080_8080;
    return k[9] ? (k ^ KEY_SEED) : (k ^ MUL_CONST);
  endfunction

  // linear in crc and word, flattens to an xor network
  function automatic logic [15:0] crc_word(logic [15:0] crc, logic [31:0] w);
    logic [31:0] c;
    c = {16'd0, crc} ^ w;
    for (int i = 0; i < 32; i++) begin
      c = c[0] ? ((c >> 1) ^ {16'd0, CRC_POLY}) : (c >> 1);
    end
    return c[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/multiboot_image_encryptor_top.sv -----
// Multiboot image encryptor. Takes one request per cycle while in_stall is low. A start
// request yields the size-derived key word; each data word yields one plain or encrypted
// word, and the word that reaches the padded image size also yields the encrypted checksum
// trailer, so the input is stalled after that request until the trailer is queued (two
// results from one key multiplier, which sets the rate: one key step per cycle). Results
// pass through a four-entry queue and an output register; with an idle output a result is
// registered in the queue and then in the output register. Configuration writes are always
// taken and must only be made while the block is idle.
// depends on mie_pkg, mie_front, mie_queue, mie_back
`default_nettype none

module multiboot_image_encryptor_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire mie_pkg::in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output mie_pkg::out_t                         out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mie_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  logic            push;
  mie_pkg::entry_t push_entry;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  mie_pkg::entry_t head;

  mie_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  mie_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mie_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ----- design/mie_front.sv -----
// front end: accepts requests and configuration, keeps session state,
// advances key and checksum and queues results; uses mie_pkg
`default_nettype none

module mie_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire mie_pkg::in_t                     in_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mie_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                      cfg_data,
  input  wire logic                             q_full,
  output logic                                  push,
  output mie_pkg::entry_t                       push_entry
);

  logic [mie_pkg::SIZE_W-1:0]   raw_image_bytes;
  logic [31:0]                  challenge_word;
  logic [mie_pkg::OFFSET_W-1:0] byte_offset;
  logic [31:0]                  stream_key;
  logic [15:0]                  running_crc;
  logic                         session_active;
  logic                         pending;
  logic [31:0]                  trail_word;
  logic [mie_pkg::OFFSET_W-1:0] trail_offset;

  logic [mie_pkg::OFFSET_W-1:0] byte_offset_next;
  logic [31:0]                  stream_key_next;
  logic [15:0]                  running_crc_next;
  logic [15:0]                  crc_step;
  logic [mie_pkg::SIZE_W-1:0]   size;
  logic [31:0]                  key_step;
  logic                         accept;
  logic                         in_plain;
  logic                         trail;

  assign cfg_ready = 1'b1;
  assign in_stall  = pending || q_full;
  assign accept    = in_valid && !in_stall;

  assign size     = mie_pkg::padded_size(raw_image_bytes);
  assign key_step = stream_key * mie_pkg::MUL_CONST + 32'd1;
  assign crc_step = mie_pkg::crc_word(running_crc, in_data.data_word);
  assign in_plain = byte_offset < mie_pkg::PLAIN_HEADER_BYTES;

  assign byte_offset_next = byte_offset + 19'd4;
  assign stream_key_next  = in_plain ? stream_key : key_step;
  assign running_crc_next = in_plain ? running_crc : crc_step;
  assign trail            = byte_offset_next >= size;

  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    if (pending) begin
      push                = !q_full;
      push_entry.word     = trail_word;
      push_entry.key      = key_step;
      push_entry.offset   = trail_offset;
      push_entry.kind     = mie_pkg::KIND_TRAILER;
      push_entry.last     = 1'b1;
      push_entry.done_res = 1'b1;
    end else if (accept) begin
      push = 1'b1;
      if (!in_data.func) begin
        push_entry.word = mie_pkg::size_key(size);
        push_entry.kind = mie_pkg::KIND_KEY;
        push_entry.last = 1'b1;
      end else if (!session_active) begin
        push_entry.kind = mie_pkg::KIND_ERROR;
        push_entry.last = 1'b1;
      end else begin
        push_entry.word   = in_data.data_word;
        push_entry.key    = key_step;
        push_entry.offset = byte_offset;
        push_entry.kind   = in_plain ? mie_pkg::KIND_PLAIN : mie_pkg::KIND_DATA;
        push_entry.last   = !trail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_image_bytes <= mie_pkg::RAW_BYTES_RESET;
      challenge_word  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mie_pkg::REG_RAW_IMAGE_BYTES: raw_image_bytes <= cfg_data[mie_pkg::SIZE_W-1:0];
        mie_pkg::REG_CHALLENGE_WORD:  challenge_word  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= '0;
      stream_key     <= '0;
      running_crc    <= mie_pkg::CRC_SEED;
      session_active <= 1'b0;
      pending        <= 1'b0;
    end else if (pending) begin
      if (!q_full) begin
        stream_key <= key_step;
        pending    <= 1'b0;
      end
    end else if (accept) begin
      if (!in_data.func) begin
        stream_key     <= mie_pkg::KEY_SEED ^ challenge_word;
        running_crc    <= mie_pkg::CRC_SEED;
        byte_offset    <= '0;
        session_active <= 1'b1;
      end else if (session_active) begin
        stream_key  <= stream_key_next;
        running_crc <= running_crc_next;
        byte_offset <= byte_offset_next;
        if (trail) begin
          session_active <= 1'b0;
          pending        <= 1'b1;
        end
      end
    end
  end

  // trailer payload
  always_ff @(posedge clk) begin
    if (accept && in_data.func && session_active) begin
      trail_word   <= {size[15:0], running_crc_next};
      trail_offset <= byte_offset_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/mie_queue.sv -----
// short result queue between front and back end
// uses mie_pkg for the entry type and depth
`default_nettype none

module mie_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mie_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output mie_pkg::entry_t      head
);

  mie_pkg::entry_t             slots [mie_pkg::QUEUE_DEPTH];
  logic [mie_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [mie_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [mie_pkg::QUEUE_CW-1:0] count;
  logic                         do_push;
  logic                         do_pop;

  assign full       = count == mie_pkg::QUEUE_CW'(mie_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- design/mie_back.sv -----
// back end: applies the word cipher and holds the output register
// uses mie_pkg
`default_nettype none

module mie_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire mie_pkg::entry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output mie_pkg::out_t        out_data
);

  logic [31:0] pad;
  logic [31:0] cipher;

  assign pad    = 32'd0 - (mie_pkg::LOAD_BASE + {13'd0, head.offset});
  assign cipher = head.word ^ head.key ^ pad ^ mie_pkg::XOR_BY;
  assign pop    = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.out_kind <= head.kind;
      out_data.last     <= head.last;
      out_data.done_res <= head.done_res;
      case (head.kind)
        mie_pkg::KIND_DATA,
        mie_pkg::KIND_TRAILER: out_data.out_word <= cipher;
        default:               out_data.out_word <= head.word;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/encryptor_monitor.sv -----
`timescale 1ns / 1ps
// monitor for the multiboot image encryptor: mirrors the key, offset and checksum
// state, works out the link words each request causes and compares them in order
// depends on mie_pkg
module encryptor_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  mie_pkg::in_t                     in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  mie_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mie_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data,
  output int                               mismatches,
  output int                               pending
);
  import mie_pkg::*;

  localparam logic FUNC_DATA  = 1'b1;

  logic [SIZE_W-1:0]   raw_bytes;
  logic [31:0]         challenge;
  logic [OFFSET_W-1:0] offset;
  logic [31:0]         key;
  logic [15:0]         crc;
  logic                active;
  out_t                link_words_due[$];
  int                  fault_count = 0;

  assign mismatches = fault_count;

  function automatic logic [SIZE_W-1:0] image_bytes(logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] r;
    r = raw;
    if (r > MAX_IMAGE_BYTES) r = MAX_IMAGE_BYTES;
    if (r < MIN_IMAGE_BYTES) return MIN_IMAGE_BYTES;
    return {r[SIZE_W-1:3] + {15'd0, |r[2:0]}, 3'b000};
  endfunction

  function automatic logic [31:0] key_word(logic [SIZE_W-1:0] size);
    logic [31:0] n;
    logic [31:0] k;
    logic [31:0] s;
    n = {13'd0, size - MIN_IMAGE_BYTES} >> 3;
    k = 32'h0070_0000;
    k[6:0] = n[6:0];
    k[14:8] = n[13:7];
    k[16] = n[14];
    s = k + (k >> 8) + (k >> 16);
    k = k | {s[7:0], 24'd0} | 32'h8080_8080;
    return k[9] ? (k ^ KEY_SEED) : (k ^ MUL_CONST);
  endfunction

  function automatic logic [15:0] crc_fold(logic [15:0] seed, logic [31:0] w);
    logic [31:0] r;
    int b;
    r = w ^ {16'd0, seed};
    for (b = 0; b < 32; b++) r = (r >> 1) ^ (r[0] ? {16'd0, CRC_POLY} : 32'd0);
    return r[15:0];
  endfunction

  // steps the stream key, then masks the word with it and the load address
  function automatic logic [31:0] scramble(logic [OFFSET_W-1:0] at, logic [31:0] w);
    key = key * MUL_CONST + 32'd1;
    return w ^ key ^ (32'd0 - (LOAD_BASE + {13'd0, at})) ^ XOR_BY;
  endfunction

  function automatic void queue_word(logic [31:0] w, logic [2:0] kind, logic fin,
                                     logic done);
    out_t r;
    r.out_word = w;
    r.out_kind = kind;
    r.last = fin;
    r.done_res = done;
    link_words_due.push_back(r);
  endfunction

  task automatic derive_link_words(in_t req);
    logic [SIZE_W-1:0] size;
    logic [31:0]       w;
    logic [2:0]        kind;
    logic              closing;
    size = image_bytes(raw_bytes);
    if (req.func != FUNC_DATA) begin
      key = KEY_SEED ^ challenge;
      crc = CRC_SEED;
      offset = '0;
      active = 1'b1;
      queue_word(key_word(size), KIND_KEY, 1'b1, 1'b0);
    end else if (!active) begin
      queue_word(32'd0, KIND_ERROR, 1'b1, 1'b0);
    end else begin
      if (offset < PLAIN_HEADER_BYTES) begin
        w = req.data_word;
        kind = KIND_PLAIN;
      end else begin
        crc = crc_fold(crc, req.data_word);
        w = scramble(offset, req.data_word);
        kind = KIND_DATA;
      end
      offset = offset + 19'd4;
      closing = (offset >= size);
      queue_word(w, kind, !closing, 1'b0);
      if (closing) begin
        queue_word(scramble(offset, {size[15:0], crc}), KIND_TRAILER, 1'b1, 1'b1);
        active = 1'b0;
      end
    end
  endtask

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    fault_count++;
    $display("%0t: %s expected %h actual %h", $time, field, want, got);
  endtask

  task automatic compare_link_word(out_t got);
    out_t want;
    if (link_words_due.size() == 0) begin
      fault_count++;
      $display("%0t: unexpected result, expected none actual %h", $time, got);
    end else begin
      want = link_words_due.pop_front();
      if (got.out_word !== want.out_word) report("out_word", want.out_word, got.out_word);
      if (got.out_kind !== want.out_kind)
        report("out_kind", {29'd0, want.out_kind}, {29'd0, got.out_kind});
      if (got.last !== want.last) report("last", {31'd0, want.last}, {31'd0, got.last});
      if (got.done_res !== want.done_res)
        report("done_res", {31'd0, want.done_res}, {31'd0, got.done_res});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      raw_bytes = RAW_BYTES_RESET;
      challenge = 32'd0;
      offset = '0;
      key = 32'd0;
      crc = CRC_SEED;
      active = 1'b0;
      link_words_due.delete();
      fault_count = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) compare_link_word(out_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RAW_IMAGE_BYTES: raw_bytes = cfg_data[SIZE_W-1:0];
          REG_CHALLENGE_WORD:  challenge = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) derive_link_words(in_data);
      pending <= link_words_due.size();
    end
  end

endmodule

// ----- tb/multiboot_image_encryptor_top_tb.sv -----
`timescale 1ns / 1ps
// testbench top for multiboot_image_encryptor_top: makes start and data requests and
// register writes with random gaps and back-pressure, and gives the verdict
// depends on mie_pkg, encryptor_monitor and the design
module multiboot_image_encryptor_top_tb;
  import mie_pkg::*;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_DATA    = 1'b1;
  localparam int   ITEM_TARGET  = 1450;
  localparam int   IDLE_LIMIT   = 2000;
  localparam int   DRAIN_CYCLES = 10;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;
  int                     mismatches;
  int                     pending;
  int                     idle_cycles = 0;
  int                     items = 0;
  int                     stall_left = 0;
  bit                     calm = 1'b0;
  logic [SIZE_W-1:0]      raw_now = RAW_BYTES_RESET;

  multiboot_image_encryptor_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  encryptor_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int image_words(logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] r;
    r = (raw > MAX_IMAGE_BYTES) ? MAX_IMAGE_BYTES : raw;
    if (r < MIN_IMAGE_BYTES) r = MIN_IMAGE_BYTES;
    return int'(({13'd0, r} + 32'd7) >> 3) * 2;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_raw();
    logic [31:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) v = $urandom_range(0, 512);
    else if (r < 72) v = $urandom_range(513, 768);
    else if (r < 86) v = $urandom_range(769, 2048);
    else if (r < 93) v = $urandom_range(2049, MAX_IMAGE_BYTES);
    else if (r < 96) v = {13'd0, MAX_IMAGE_BYTES};
    else v = $urandom_range(MAX_IMAGE_BYTES + 1, 19'h7FFFF);
    // bits above the register width are dropped by the block
    if ($urandom_range(0, 3) == 0) v = v | ($urandom << SIZE_W);
    return v;
  endfunction

  function automatic logic [31:0] pick_challenge();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic func, logic [31:0] word);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: func, data_word: word};
    do @(posedge clk); while (in_stall);
    items++;
  endtask

  // wait until every expected word has left the block
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == REG_RAW_IMAGE_BYTES) raw_now = value[SIZE_W-1:0];
  endtask

  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_left = gap_len();
      out_stall <= ~out_stall;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int total;
    int cut;
    int choice;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // data with no session open, then a session on the reset settings
    send(FUNC_DATA, 32'hFFFF_FFFF);
    send(FUNC_DATA, 32'h0000_0000);
    send(FUNC_START, 32'h0000_0000);
    send(FUNC_DATA, 32'hFFFF_FFFF);
    send(FUNC_DATA, 32'h0000_0000);
    // oversized image, restart while a session is open
    cfg_write(REG_RAW_IMAGE_BYTES, 32'hFFFF_FFFF);
    cfg_write(REG_CHALLENGE_WORD, 32'hFFFF_FFFF);
    send(FUNC_START, 32'hFFFF_FFFF);
    send(FUNC_DATA, 32'h8000_0001);
    cfg_write(REG_RAW_IMAGE_BYTES, 32'h0000_0000);
    send(FUNC_START, $urandom);
    send(FUNC_DATA, 32'h7FFF_FFFE);
    cfg_write(REG_RAW_IMAGE_BYTES, {13'd0, MAX_IMAGE_BYTES});
    send(FUNC_START, 32'h0000_0000);
    cfg_write(REG_RAW_IMAGE_BYTES, 32'h0000_0201);
    send(FUNC_START, 32'h0000_0000);
    // new challenge only counts from the next start
    cfg_write(REG_CHALLENGE_WORD, 32'h0000_0000);
    send(FUNC_DATA, $urandom);
    send(FUNC_DATA, $urandom);

    while (items < ITEM_TARGET) begin
      calm = ($urandom_range(0, 7) == 0);
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        repeat ($urandom_range(1, 6)) send(1'($urandom_range(0, 1)), rand_word());
      end else begin
        if ($urandom_range(0, 3) != 0) cfg_write(REG_RAW_IMAGE_BYTES, pick_raw());
        if ($urandom_range(0, 2) == 0) cfg_write(REG_CHALLENGE_WORD, pick_challenge());
        send(FUNC_START, rand_word());
        total = image_words(raw_now);
        choice = $urandom_range(0, 9);
        if (total > 300 || choice == 0) begin
          // shrink the image part way through
          cut = (total > 300) ? $urandom_range(100, 200) : $urandom_range(1, total - 1);
          repeat (cut) send(FUNC_DATA, rand_word());
          cfg_write(REG_RAW_IMAGE_BYTES, $urandom_range(0, 4 * cut + 64));
          total = image_words(raw_now);
          if (total <= cut) total = cut + 1;
          repeat (total - cut) send(FUNC_DATA, rand_word());
        end else if (choice == 1) begin
          // abandoned image
          repeat ($urandom_range(1, total - 1)) send(FUNC_DATA, rand_word());
          if ($urandom_range(0, 1) == 1) cfg_write(REG_CHALLENGE_WORD, pick_challenge());
        end else begin
          repeat (total) send(FUNC_DATA, rand_word());
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
